// ===== rtl/core/kdtb_pkg.sv =====
// Shared widths, register codes, direction table and arithmetic helpers for kdop_triangle_bounds.
package kdtb_pkg;

    localparam int COORD_W   = 32;
    localparam int NUM_DIR   = 13;
    localparam int AXIS_W    = 4;
    localparam int LEAF_W    = 20;
    localparam int SET_W     = 3;
    localparam int MARGIN_W  = 21;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = MARGIN_W;
    localparam int BOUND_W   = COORD_W + 3;
    // a sum of three coordinates
    localparam int SUM_W     = COORD_W + 2;
    // wide enough for sum plus or minus margin, and for the bound limits
    localparam int ARITH_W   = ((SUM_W > MARGIN_W) ? SUM_W : MARGIN_W) + 1;
    localparam int XW        = (ARITH_W > BOUND_W) ? ARITH_W : BOUND_W;

    localparam logic signed [XW-1:0] BMAX_X = (XW'(1) <<< (BOUND_W - 1)) - XW'(1);
    localparam logic signed [XW-1:0] BMIN_X = -BMAX_X - XW'(1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_SET       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_INFLATE_MARGIN = CFG_IDX_W'(1);

    // axis set codes
    localparam logic [SET_W-1:0] SET_AXES_0_2  = SET_W'(0);
    localparam logic [SET_W-1:0] SET_AXES_0_3  = SET_W'(1);
    localparam logic [SET_W-1:0] SET_AXES_0_6  = SET_W'(2);
    localparam logic [SET_W-1:0] SET_AXES_7_12 = SET_W'(3);
    localparam logic [SET_W-1:0] SET_AXES_ALL  = SET_W'(4);

    // direction component codes
    localparam logic [1:0] DC_ZERO = 2'd0;
    localparam logic [1:0] DC_POS  = 2'd1;
    localparam logic [1:0] DC_NEG  = 2'd2;

    typedef logic [2:0][COORD_W-1:0] vertex_t;
    typedef logic [2:0][1:0]         dir_t;

    typedef struct packed {
        logic                valid;
        logic [AXIS_W-1:0]   axis;
        logic                last;
        logic [LEAF_W-1:0]   leaf;
        logic [2:0][2:0][COORD_W-1:0] verts;
    } issue_t;

    typedef struct packed {
        logic                valid;
        logic [AXIS_W-1:0]   axis;
        logic                last;
        logic [LEAF_W-1:0]   leaf;
        logic [2:0][SUM_W-1:0] proj;
    } proj_t;

    typedef struct packed {
        logic                valid;
        logic [AXIS_W-1:0]   axis;
        logic                last;
        logic [LEAF_W-1:0]   leaf;
        logic [SUM_W-1:0]    mn;
        logic [SUM_W-1:0]    mx;
    } span_t;

    function automatic logic [AXIS_W-1:0] set_first(input logic [SET_W-1:0] s);
        logic [AXIS_W-1:0] f;
        f = '0;
        if (s == SET_AXES_7_12)
        begin
            f = AXIS_W'(7);
        end
        return f;
    endfunction

    // end is exclusive; unknown codes give an empty set
    function automatic logic [AXIS_W-1:0] set_end(input logic [SET_W-1:0] s);
        logic [AXIS_W-1:0] e;
        unique case (s)
            SET_AXES_0_2:  e = AXIS_W'(3);
            SET_AXES_0_3:  e = AXIS_W'(4);
            SET_AXES_0_6:  e = AXIS_W'(7);
            SET_AXES_7_12: e = AXIS_W'(13);
            SET_AXES_ALL:  e = AXIS_W'(13);
            default:       e = '0;
        endcase
        if (e > AXIS_W'(NUM_DIR))
        begin
            e = AXIS_W'(NUM_DIR);
        end
        return e;
    endfunction

    // components ordered [0]=x, [1]=y, [2]=z
    function automatic dir_t dir_code(input logic [AXIS_W-1:0] a);
        dir_t d;
        unique case (a)
            4'd0:    d = {DC_ZERO, DC_ZERO, DC_POS };
            4'd1:    d = {DC_ZERO, DC_POS,  DC_ZERO};
            4'd2:    d = {DC_POS,  DC_ZERO, DC_ZERO};
            4'd3:    d = {DC_POS,  DC_POS,  DC_POS };
            4'd4:    d = {DC_POS,  DC_NEG,  DC_POS };
            4'd5:    d = {DC_NEG,  DC_POS,  DC_POS };
            4'd6:    d = {DC_NEG,  DC_NEG,  DC_POS };
            4'd7:    d = {DC_ZERO, DC_POS,  DC_POS };
            4'd8:    d = {DC_POS,  DC_ZERO, DC_POS };
            4'd9:    d = {DC_POS,  DC_POS,  DC_ZERO};
            4'd10:   d = {DC_ZERO, DC_NEG,  DC_POS };
            4'd11:   d = {DC_NEG,  DC_ZERO, DC_POS };
            4'd12:   d = {DC_NEG,  DC_POS,  DC_ZERO};
            default: d = {DC_ZERO, DC_ZERO, DC_ZERO};
        endcase
        return d;
    endfunction

    function automatic logic signed [SUM_W-1:0] project(input vertex_t v, input dir_t d);
        logic signed [SUM_W-1:0] acc;
        logic signed [SUM_W-1:0] c;
        acc = '0;
        for (int k = 0; k < 3; k++)
        begin
            c = SUM_W'($signed(v[k]));
            case (d[k])
                DC_POS:  acc = acc + c;
                DC_NEG:  acc = acc - c;
                default: acc = acc;
            endcase
        end
        return acc;
    endfunction

    function automatic logic [BOUND_W-1:0] sat_bound(input logic signed [XW-1:0] v);
        logic [BOUND_W-1:0] r;
        if (v > BMAX_X)
        begin
            r = BMAX_X[BOUND_W-1:0];
        end
        else if (v < BMIN_X)
        begin
            r = BMIN_X[BOUND_W-1:0];
        end
        else
        begin
            r = v[BOUND_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/kdop_triangle_bounds.sv =====
// Top level: k-DOP bounds of one triangle, one bound pair per axis per cycle
//   while out_ready does not hold the pipeline. A request passes the holding
//   register, projection, min/max, and margin + output register in that order.
// The axis sequencer issues every axis of the set (3, 4, 7, 6 or 13 of them) and
//   takes the next triangle on the last one; an empty set yields no results.
// Reset: asynchronous active-low; clears all valid bits, axis_set to 0, margin to 1.
module kdop_triangle_bounds (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [kdtb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [kdtb_pkg::CFG_DAT_W-1:0]       cfg_data,
    // triangle requests
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [kdtb_pkg::COORD_W-1:0]  ax,
    input  logic signed [kdtb_pkg::COORD_W-1:0]  ay,
    input  logic signed [kdtb_pkg::COORD_W-1:0]  az,
    input  logic signed [kdtb_pkg::COORD_W-1:0]  bx,
    input  logic signed [kdtb_pkg::COORD_W-1:0]  by,
    input  logic signed [kdtb_pkg::COORD_W-1:0]  bz,
    input  logic signed [kdtb_pkg::COORD_W-1:0]  cx,
    input  logic signed [kdtb_pkg::COORD_W-1:0]  cy,
    input  logic signed [kdtb_pkg::COORD_W-1:0]  cz,
    input  logic [kdtb_pkg::LEAF_W-1:0]          leaf_id,
    // bound results
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [kdtb_pkg::AXIS_W-1:0]          axis_number,
    output logic signed [kdtb_pkg::BOUND_W-1:0]  low_bound,
    output logic signed [kdtb_pkg::BOUND_W-1:0]  high_bound,
    output logic [kdtb_pkg::LEAF_W-1:0]          leaf_tag,
    output logic                                 last_axis
);
    import kdtb_pkg::*;

    logic [SET_W-1:0]              axis_set_reg;
    logic [MARGIN_W-1:0]           margin_reg;
    logic [MARGIN_W-1:0]           eps;
    logic                          advance;
    logic [2:0][2:0][COORD_W-1:0]  verts;
    issue_t                        issue;
    proj_t                         prj;
    span_t                         span;
    logic [BOUND_W-1:0]            low_raw;
    logic [BOUND_W-1:0]            high_raw;

    // Config writes always land; the user sends them only while idle; not enforced.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_set_reg <= SET_AXES_0_2;
            margin_reg   <= MARGIN_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_AXIS_SET:       axis_set_reg <= cfg_data[SET_W-1:0];
                REG_INFLATE_MARGIN: margin_reg   <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Margin floor of one LSB.
    assign eps = (margin_reg == '0) ? MARGIN_W'(1) : margin_reg;

    // Whole pipeline moves together; it only holds when a finished result waits.
    assign advance = !out_valid || out_ready;

    // vertex i, component k: [0]=x, [1]=y, [2]=z
    assign verts = {{cz, cy, cx}, {bz, by, bx}, {az, ay, ax}};

    kdtb_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .verts    (verts),
        .leaf_id  (leaf_id),
        .axis_set (axis_set_reg),
        .advance  (advance),
        .issue    (issue)
    );

    kdtb_proj u_proj (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .issue   (issue),
        .stage   (prj)
    );

    kdtb_minmax u_minmax (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .prj     (prj),
        .stage   (span)
    );

    kdtb_bound u_bound (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .span        (span),
        .eps         (eps),
        .out_valid   (out_valid),
        .axis_number (axis_number),
        .low_bound   (low_raw),
        .high_bound  (high_raw),
        .leaf_tag    (leaf_tag),
        .last_axis   (last_axis)
    );

    assign low_bound  = $signed(low_raw);
    assign high_bound = $signed(high_raw);

endmodule

// ===== rtl/core/kdtb_seq.sv =====
// Triangle holding register and axis sequencer: issues one axis per cycle unless the pipeline stalls.
module kdtb_seq (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [2:0][2:0][kdtb_pkg::COORD_W-1:0] verts,
    input  logic [kdtb_pkg::LEAF_W-1:0]       leaf_id,
    input  logic [kdtb_pkg::SET_W-1:0]        axis_set,
    input  logic                              advance,
    output kdtb_pkg::issue_t                  issue
);
    import kdtb_pkg::*;

    logic                          busy_reg,  busy_next;
    logic [AXIS_W-1:0]             axis_reg,  axis_next;
    logic [AXIS_W-1:0]             end_reg,   end_next;
    logic [2:0][2:0][COORD_W-1:0]  verts_reg;
    logic [LEAF_W-1:0]             leaf_reg;
    logic                          last;
    logic                          accept;
    logic [AXIS_W-1:0]             first_sel;
    logic [AXIS_W-1:0]             end_sel;

    assign last      = (axis_reg + AXIS_W'(1)) == end_reg;
    assign in_ready  = !busy_reg || (advance && last);
    assign accept    = in_valid && in_ready;
    assign first_sel = set_first(axis_set);
    assign end_sel   = set_end(axis_set);

    always_comb
    begin
        busy_next = busy_reg;
        axis_next = axis_reg;
        end_next  = end_reg;
        if (accept)
        begin
            // empty set: request is consumed with no results
            busy_next = first_sel < end_sel;
            axis_next = first_sel;
            end_next  = end_sel;
        end
        else if (busy_reg && advance)
        begin
            busy_next = !last;
            axis_next = axis_reg + AXIS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            axis_reg <= '0;
            end_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            axis_reg <= axis_next;
            end_reg  <= end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            verts_reg <= verts;
            leaf_reg  <= leaf_id;
        end
    end

    assign issue.valid = busy_reg;
    assign issue.axis  = axis_reg;
    assign issue.last  = last;
    assign issue.leaf  = leaf_reg;
    assign issue.verts = verts_reg;

endmodule

// ===== rtl/core/kdtb_proj.sv =====
// Projection stage: three vertex projections onto the issued axis.
module kdtb_proj (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  kdtb_pkg::issue_t  issue,
    output kdtb_pkg::proj_t   stage
);
    import kdtb_pkg::*;

    proj_t stage_reg, stage_next;
    dir_t  dir;

    assign dir = dir_code(issue.axis);

    always_comb
    begin
        stage_next.valid = issue.valid;
        stage_next.axis  = issue.axis;
        stage_next.last  = issue.last;
        stage_next.leaf  = issue.leaf;
        for (int i = 0; i < 3; i++)
        begin
            stage_next.proj[i] = project(issue.verts[i], dir);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else if (advance)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage = stage_reg;

endmodule

// ===== rtl/core/kdtb_minmax.sv =====
// Min/max stage over the three projections.
module kdtb_minmax (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  kdtb_pkg::proj_t   prj,
    output kdtb_pkg::span_t   stage
);
    import kdtb_pkg::*;

    span_t stage_reg, stage_next;
    logic signed [SUM_W-1:0] p0, p1, p2;
    logic signed [SUM_W-1:0] mn01, mx01;

    assign p0   = $signed(prj.proj[0]);
    assign p1   = $signed(prj.proj[1]);
    assign p2   = $signed(prj.proj[2]);
    assign mn01 = (p1 < p0) ? p1 : p0;
    assign mx01 = (p1 > p0) ? p1 : p0;

    always_comb
    begin
        stage_next.valid = prj.valid;
        stage_next.axis  = prj.axis;
        stage_next.last  = prj.last;
        stage_next.leaf  = prj.leaf;
        stage_next.mn    = (p2 < mn01) ? p2 : mn01;
        stage_next.mx    = (p2 > mx01) ? p2 : mx01;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else if (advance)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage = stage_reg;

endmodule

// ===== rtl/core/kdtb_bound.sv =====
// Margin stage and output register: widens the span and holds the result request.
module kdtb_bound (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  kdtb_pkg::span_t               span,
    input  logic [kdtb_pkg::MARGIN_W-1:0] eps,
    output logic                          out_valid,
    output logic [kdtb_pkg::AXIS_W-1:0]   axis_number,
    output logic [kdtb_pkg::BOUND_W-1:0]  low_bound,
    output logic [kdtb_pkg::BOUND_W-1:0]  high_bound,
    output logic [kdtb_pkg::LEAF_W-1:0]   leaf_tag,
    output logic                          last_axis
);
    import kdtb_pkg::*;

    logic                     valid_reg;
    logic [AXIS_W-1:0]        axis_reg;
    logic [BOUND_W-1:0]       low_reg,  low_next;
    logic [BOUND_W-1:0]       high_reg, high_next;
    logic [LEAF_W-1:0]        leaf_reg;
    logic                     last_reg;
    logic signed [XW-1:0]     eps_x;
    logic signed [XW-1:0]     low_x;
    logic signed [XW-1:0]     high_x;

    assign eps_x     = XW'($signed({1'b0, eps}));
    assign low_x     = XW'($signed(span.mn)) - eps_x;
    assign high_x    = XW'($signed(span.mx)) + eps_x;
    assign low_next  = sat_bound(low_x);
    assign high_next = sat_bound(high_x);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= span.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            axis_reg <= span.axis;
            low_reg  <= low_next;
            high_reg <= high_next;
            leaf_reg <= span.leaf;
            last_reg <= span.last;
        end
    end

    assign out_valid   = valid_reg;
    assign axis_number = axis_reg;
    assign low_bound   = low_reg;
    assign high_bound  = high_reg;
    assign leaf_tag    = leaf_reg;
    assign last_axis   = last_reg;

endmodule

// ===== verif/kdop_triangle_bounds_test.sv =====
// Self-checking kdop_triangle_bounds testbench: directed and random triangles vs. k-DOP bound predictor.
module kdop_triangle_bounds_test;
    timeunit 1ns;
    timeprecision 1ps;

    import kdtb_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 11;
    // leave margin for in-flight requests before a register write
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 200;
    // longest legal quiet stretch is the receiver hold; allow well beyond it
    localparam int QUIET_LIMIT  = 2000;
    localparam int MAX_REPORTS  = 40;

    // idle percentages per traffic mode
    localparam int IDLE_LOW  = 27;
    localparam int IDLE_HIGH = 79;

    // axis_set codes with no directions behind them
    localparam logic [SET_W-1:0] SET_UNKNOWN_5 = SET_W'(5);
    localparam logic [SET_W-1:0] SET_UNKNOWN_6 = SET_W'(6);
    localparam logic [SET_W-1:0] SET_UNKNOWN_7 = SET_W'(7);

    localparam logic [MARGIN_W-1:0] MARGIN_ZERO = '0;
    localparam logic [MARGIN_W-1:0] MARGIN_ONE  = MARGIN_W'(1);
    localparam logic [MARGIN_W-1:0] MARGIN_BIG  = MARGIN_W'(1048576);
    localparam logic [MARGIN_W-1:0] MARGIN_FULL = '1;

    localparam logic [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [COORD_W-1:0] Q_ONE = COORD_W'(65536);

    typedef logic [2:0][COORD_W-1:0] point_t;   // [0]=x, [1]=y, [2]=z

    // one triangle request: crd[0..8] = ax ay az bx by bz cx cy cz
    typedef struct packed {
        logic [8:0][COORD_W-1:0] crd;
        logic [LEAF_W-1:0]       leaf;
    } triangle_t;

    // one bound pair as it should leave the block
    typedef struct packed {
        logic [AXIS_W-1:0]  axis;
        logic [BOUND_W-1:0] lo;
        logic [BOUND_W-1:0] hi;
        logic [LEAF_W-1:0]  leaf;
        logic               last;
    } bound_pair_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    logic      in_valid = 1'b0;
    logic      in_ready;
    triangle_t cur_tri  = '0;

    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [AXIS_W-1:0]          axis_number;
    logic signed [BOUND_W-1:0]  low_bound;
    logic signed [BOUND_W-1:0]  high_bound;
    logic [LEAF_W-1:0]          leaf_tag;
    logic                       last_axis;

    triangle_t   pending_tris[$];
    bound_pair_t expected_bounds[$];

    // shadow of the two registers, updated when a write is taken
    logic [SET_W-1:0]    cur_axis_set = SET_AXES_0_2;
    logic [MARGIN_W-1:0] cur_margin   = MARGIN_ONE;

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_arm      = 1'b0;
    logic hold_done     = 1'b0;
    int   hold_left     = 0;
    int   quiet_cycles  = 0;
    int   error_count   = 0;

    kdop_triangle_bounds i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .ax          (cur_tri.crd[0]),
        .ay          (cur_tri.crd[1]),
        .az          (cur_tri.crd[2]),
        .bx          (cur_tri.crd[3]),
        .by          (cur_tri.crd[4]),
        .bz          (cur_tri.crd[5]),
        .cx          (cur_tri.crd[6]),
        .cy          (cur_tri.crd[7]),
        .cz          (cur_tri.crd[8]),
        .leaf_id     (cur_tri.leaf),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .axis_number (axis_number),
        .low_bound   (low_bound),
        .high_bound  (high_bound),
        .leaf_tag    (leaf_tag),
        .last_axis   (last_axis)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Component of direction a along coordinate k (0=x, 1=y, 2=z).
    function automatic int axis_weight(input int a, input int k);
        int w [3];
        case (a)
            0:       w = '{1,  0,  0};
            1:       w = '{0,  1,  0};
            2:       w = '{0,  0,  1};
            3:       w = '{1,  1,  1};
            4:       w = '{1, -1,  1};
            5:       w = '{1,  1, -1};
            6:       w = '{1, -1, -1};
            7:       w = '{1,  1,  0};
            8:       w = '{1,  0,  1};
            9:       w = '{0,  1,  1};
            10:      w = '{1, -1,  0};
            11:      w = '{1,  0, -1};
            12:      w = '{0,  1, -1};
            default: w = '{0,  0,  0};
        endcase
        return w[k];
    endfunction

    // Min/max projection of the three vertices on every direction of the
    // current set, widened by the margin. Projections are exact in 64 bits
    // and always fit the 35-bit bound, so plain truncation is enough.
    task automatic predict_bounds(input triangle_t t);
        int          first_axis;
        int          end_axis;
        longint      eps;
        longint      mn;
        longint      mx;
        longint      p;
        bound_pair_t b;
        first_axis = 0;
        end_axis   = 0;
        case (cur_axis_set)
            SET_AXES_0_2:  end_axis = 3;
            SET_AXES_0_3:  end_axis = 4;
            SET_AXES_0_6:  end_axis = 7;
            SET_AXES_7_12:
            begin
                first_axis = 7;
                end_axis   = 13;
            end
            SET_AXES_ALL:  end_axis = 13;
            default:       end_axis = 0;   // unknown code: request swallowed
        endcase
        // zero margin is treated as one LSB
        eps = (cur_margin == MARGIN_ZERO) ? 64'sd1 : longint'(cur_margin);
        mn  = 0;
        mx  = 0;
        for (int a = first_axis; a < end_axis; a++)
        begin
            for (int v = 0; v < 3; v++)
            begin
                p = 0;
                for (int k = 0; k < 3; k++)
                begin
                    p += axis_weight(a, k) * longint'($signed(t.crd[v*3+k]));
                end
                if (v == 0 || p < mn)
                begin
                    mn = p;
                end
                if (v == 0 || p > mx)
                begin
                    mx = p;
                end
            end
            b.axis = AXIS_W'(a);
            b.lo   = BOUND_W'(mn - eps);
            b.hi   = BOUND_W'(mx + eps);
            b.leaf = t.leaf;
            b.last = (a == end_axis - 1);
            expected_bounds.push_back(b);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic point_t pt(input logic [COORD_W-1:0] x,
                                  input logic [COORD_W-1:0] y,
                                  input logic [COORD_W-1:0] z);
        return {z, y, x};
    endfunction

    function automatic triangle_t make_tri(input point_t a, input point_t b, input point_t c,
                                           input logic [LEAF_W-1:0] leaf);
        triangle_t t;
        t.crd  = {c, b, a};
        t.leaf = leaf;
        return t;
    endfunction

    function automatic logic [COORD_W-1:0] rand_extreme();
        case ($urandom_range(4))
            0:       return C_MIN;
            1:       return C_MAX;
            2:       return '0;
            3:       return '1;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic logic [LEAF_W-1:0] rand_leaf();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return LEAF_W'($urandom);
        endcase
    endfunction

    // Half small mesh-like triangles around an anchor, the rest fully random
    // coordinates or built from range extremes.
    function automatic triangle_t rand_triangle();
        triangle_t t;
        point_t    anchor;
        int        kind;
        kind = $urandom_range(9);
        for (int k = 0; k < 3; k++)
        begin
            anchor[k] = COORD_W'($urandom);
        end
        for (int i = 0; i < 9; i++)
        begin
            if (kind < 5)
            begin
                t.crd[i] = anchor[i % 3] + COORD_W'($urandom_range(0, 1 << 20))
                           - COORD_W'(1 << 19);
            end
            else if (kind < 8)
            begin
                t.crd[i] = COORD_W'($urandom);
            end
            else
            begin
                t.crd[i] = rand_extreme();
            end
        end
        t.leaf = rand_leaf();
        return t;
    endfunction

    task automatic push_random(input int n);
        repeat (n)
        begin
            pending_tris.push_back(rand_triangle());
        end
    endtask

    // triangles built from the ends of the coordinate range, so projections reach their extremes
    task automatic push_extremes();
        pending_tris.push_back(make_tri(pt(C_MIN, C_MIN, C_MIN), pt(C_MIN, C_MIN, C_MIN),
                                        pt(C_MIN, C_MIN, C_MIN), '1));
        pending_tris.push_back(make_tri(pt(C_MAX, C_MAX, C_MAX), pt(C_MAX, C_MAX, C_MAX),
                                        pt(C_MAX, C_MAX, C_MAX), LEAF_W'(1)));
        pending_tris.push_back(make_tri(pt(C_MAX, C_MAX, C_MAX), pt(C_MIN, C_MIN, C_MIN),
                                        pt('0, '0, '0), LEAF_W'('h55555)));
        pending_tris.push_back(make_tri(pt(C_MAX, C_MIN, C_MAX), pt(C_MIN, C_MAX, C_MIN),
                                        pt(C_MAX, C_MAX, C_MIN), LEAF_W'('hAAAAA)));
        pending_tris.push_back(make_tri(pt(C_MIN, C_MAX, C_MIN), pt(C_MAX, C_MIN, C_MAX),
                                        pt(C_MIN, C_MIN, C_MAX), LEAF_W'('h0F0F0)));
    endtask

    // ------------------------------------------------------------------
    // Register writes and phase control (only while the block is idle)
    // ------------------------------------------------------------------

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] dat);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= dat;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_AXIS_SET)
        begin
            cur_axis_set = dat[SET_W-1:0];
        end
        else if (idx == REG_INFLATE_MARGIN)
        begin
            cur_margin = dat[MARGIN_W-1:0];
        end
    endtask

    task automatic configure(input logic [SET_W-1:0] set_code, input logic [MARGIN_W-1:0] margin,
                             input int send_pct, input int recv_pct);
        write_reg(REG_AXIS_SET, CFG_DAT_W'(set_code));
        write_reg(REG_INFLATE_MARGIN, CFG_DAT_W'(margin));
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Sampled on the falling edge so the driver's and monitor's updates at
    // the rising edge are settled. The trailing pause covers requests that
    // yield no result but may still be in flight.
    task automatic wait_idle();
        while (pending_tris.size() != 0 || in_valid || expected_bounds.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_REPORTS)
        begin
            $display("%0t: %s", $realtime, msg);
        end
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [BOUND_W-1:0] got,
                               input logic [BOUND_W-1:0] want, input bound_pair_t ctx);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s mismatch: got %h, expected %h (axis %0d, leaf %h)",
                                      name, got, want, ctx.axis, ctx.leaf));
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued triangles; predicts results when a request is taken
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_triangles
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_bounds(cur_tri);
            end
            // payload is held until taken; a new one goes out only after that
            if (!in_valid || in_ready)
            begin
                if (pending_tris.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_tri  <= pending_tris.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each bound pair against the oldest prediction and
    // drives out_ready, including the one long hold-off that backs up the
    // block until it refuses new requests.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : check_bounds
        bound_pair_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_bounds.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result: axis %0d, leaf %h",
                                              axis_number, leaf_tag));
                end
                else
                begin
                    want = expected_bounds.pop_front();
                    check_field("axis_number", BOUND_W'(axis_number), BOUND_W'(want.axis),
                                want);
                    check_field("low_bound", low_bound, want.lo, want);
                    check_field("high_bound", high_bound, want.hi, want);
                    check_field("leaf_tag", BOUND_W'(leaf_tag), BOUND_W'(want.leaf), want);
                    check_field("last_axis", BOUND_W'(last_axis), BOUND_W'(want.last), want);
                end
            end
            if (hold_arm && !hold_done)
            begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
                out_ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: too many cycles without any handshake means a hang.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("kdop_triangle_bounds_test: errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: all 13 directions, zero margin (one LSB), range ends,
        // unit vectors, a degenerate point triangle and leaf extremes.
        configure(SET_AXES_ALL, MARGIN_ZERO, IDLE_LOW, IDLE_HIGH);
        pending_tris.push_back(make_tri(pt('0, '0, '0), pt('0, '0, '0), pt('0, '0, '0), '0));
        push_extremes();
        pending_tris.push_back(make_tri(pt(Q_ONE, '0, '0), pt('0, Q_ONE, '0),
                                        pt('0, '0, Q_ONE), LEAF_W'('h12345)));
        pending_tris.push_back(make_tri(pt(-Q_ONE, '0, Q_ONE), pt('1, '1, '1),
                                        pt(Q_ONE, -Q_ONE, '0), LEAF_W'('hFEDCB)));
        pending_tris.push_back(make_tri(pt(C_MIN, C_MAX, '0), pt('0, C_MIN, C_MAX),
                                        pt(C_MAX, '0, C_MIN), LEAF_W'('h00001)));
        begin : same_point
            point_t p;
            p = pt(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
            pending_tris.push_back(make_tri(p, p, p, rand_leaf()));
        end
        wait_idle();

        // sender idles little, receiver much
        configure(SET_AXES_0_2, MARGIN_ONE, IDLE_LOW, IDLE_HIGH);
        push_random(60);
        wait_idle();

        // unknown set: requests are taken and produce nothing
        configure(SET_UNKNOWN_5, MARGIN_BIG, IDLE_LOW, IDLE_HIGH);
        push_random(5);
        wait_idle();

        // roles swapped: sender idles much, receiver little
        configure(SET_AXES_0_3, MARGIN_BIG, IDLE_HIGH, IDLE_LOW);
        push_random(60);
        wait_idle();

        configure(SET_AXES_0_6, MARGIN_W'($urandom), IDLE_HIGH, IDLE_LOW);
        push_random(60);
        wait_idle();

        configure(SET_AXES_7_12, MARGIN_W'($urandom), IDLE_HIGH, IDLE_LOW);
        push_random(60);
        wait_idle();

        // no idling from here on
        configure(SET_UNKNOWN_7, MARGIN_ZERO, 0, 0);
        push_random(4);
        wait_idle();

        configure(SET_UNKNOWN_6, MARGIN_FULL, 0, 0);
        push_random(3);
        wait_idle();

        // full set at the largest margin; receiver stalls for a long
        // stretch while requests keep coming, so the block backs up
        configure(SET_AXES_ALL, MARGIN_FULL, 0, 0);
        push_extremes();
        push_random(90);
        @(posedge clk);
        hold_arm <= 1'b1;
        wait_idle();

        configure(SET_AXES_0_2, MARGIN_W'($urandom), 0, 0);
        push_random(60);
        wait_idle();

        if (error_count == 0)
        begin
            $display("kdop_triangle_bounds_test: clean");
        end
        else
        begin
            $display("kdop_triangle_bounds_test: errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/kdtb_pkg.sv
rtl/core/kdtb_seq.sv
rtl/core/kdtb_proj.sv
rtl/core/kdtb_minmax.sv
rtl/core/kdtb_bound.sv
rtl/core/kdop_triangle_bounds.sv
verif/kdop_triangle_bounds_test.sv
